// File: design/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants for the ray-casting point-in-polygon test.
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam int MaxVertices = 64;
  localparam int IdxW        = 6;   // vertex store address
  localparam int CntW        = 7;   // vertex count, holds MaxVertices itself
  localparam int LatW        = 31;
  localparam int LonW        = 32;

  localparam logic ActLoad  = 1'b0;
  localparam logic ActQuery = 1'b1;

  typedef struct packed {
    logic signed [LatW-1:0] lat;
    logic signed [LonW-1:0] lon;
  } vertex_t;

  // control from the sequencer to the edge unit
  typedef struct packed {
    logic valid;   // a/b edge presented this cycle
    logic clear;   // new query: drop the inside flag
  } edge_ctl_t;

endpackage

// File: design/pip_vertex_store.sv
// ----------------------------------------------------------------------------
// pip_vertex_store
// Polygon vertex memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pip_vertex_store (
  input  logic                    clk_i,
  input  logic                    wr_en_i,
  input  logic [pip_pkg::IdxW-1:0] wr_addr_i,
  input  pip_pkg::vertex_t        wr_data_i,
  input  logic                    rd_en_i,
  input  logic [pip_pkg::IdxW-1:0] rd_addr_i,
  output pip_pkg::vertex_t        rd_data_o
);

  pip_pkg::vertex_t mem_q [pip_pkg::MaxVertices];
  pip_pkg::vertex_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: design/pip_edge_unit.sv
// ----------------------------------------------------------------------------
// pip_edge_unit
// Shared edge test: straddle check, cross-multiplied latitude compare and
// the running inside flag. Three stages, one edge accepted per cycle.
// ----------------------------------------------------------------------------
module pip_edge_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pip_pkg::edge_ctl_t ctl_i,
  input  pip_pkg::vertex_t   a_i,
  input  pip_pkg::vertex_t   b_i,
  input  pip_pkg::vertex_t   pt_i,
  output logic               busy_o,
  output logic               inside_o
);

  logic signed [pip_pkg::LatW-1:0] a_lat, b_lat, p_lat;
  logic signed [pip_pkg::LonW-1:0] a_lon, b_lon, p_lon;

  assign a_lat = a_i.lat;
  assign b_lat = b_i.lat;
  assign p_lat = pt_i.lat;
  assign a_lon = a_i.lon;
  assign b_lon = b_i.lon;
  assign p_lon = pt_i.lon;

  // stage 1: differences and straddle
  logic                              s1_valid_q, s1_straddle_q;
  logic signed [pip_pkg::LatW:0]     s1_dlat_p_q, s1_dlat_ab_q;  // p-b, a-b
  logic signed [pip_pkg::LonW:0]     s1_dlon_q, s1_dlon_p_q;     // a-b, p-b

  // stage 2: products, wrapped to 64 bits
  logic                              s2_valid_q, s2_straddle_q, s2_dneg_q;
  logic signed [63:0]                s2_lhs_q, s2_rhs_q;
  logic signed [pip_pkg::LatW+pip_pkg::LonW+1:0] lhs_full, rhs_full;

  logic inside_q, inside_d, hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= ctl_i.valid;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_straddle_q <= (a_lon > p_lon) != (b_lon > p_lon);
    s1_dlat_p_q   <= (pip_pkg::LatW+1)'(p_lat) - (pip_pkg::LatW+1)'(b_lat);
    s1_dlat_ab_q  <= (pip_pkg::LatW+1)'(a_lat) - (pip_pkg::LatW+1)'(b_lat);
    s1_dlon_q     <= (pip_pkg::LonW+1)'(a_lon) - (pip_pkg::LonW+1)'(b_lon);
    s1_dlon_p_q   <= (pip_pkg::LonW+1)'(p_lon) - (pip_pkg::LonW+1)'(b_lon);
  end

  assign lhs_full = s1_dlat_p_q  * s1_dlon_q;
  assign rhs_full = s1_dlat_ab_q * s1_dlon_p_q;

  always_ff @(posedge clk_i) begin
    s2_straddle_q <= s1_straddle_q;
    s2_dneg_q     <= s1_dlon_q[pip_pkg::LonW];
    s2_lhs_q      <= $signed(lhs_full[63:0]);
    s2_rhs_q      <= $signed(rhs_full[63:0]);
  end

  // stage 3: compare, sense flipped for a falling edge
  assign hit = s2_valid_q && s2_straddle_q &&
               (s2_dneg_q ? (s2_lhs_q > s2_rhs_q) : (s2_lhs_q < s2_rhs_q));

  always_comb begin
    inside_d = inside_q;
    if (ctl_i.clear) begin
      inside_d = 1'b0;
    end else if (hit) begin
      inside_d = !inside_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
    end else begin
      inside_q <= inside_d;
    end
  end

  assign busy_o   = s1_valid_q || s2_valid_q;
  assign inside_o = inside_q;

endmodule

// File: design/point_in_polygon_test.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test
// Ray-casting geofence: vertex loads fill a store, a query walks every edge
// through one shared edge unit and returns the inside flag.
// ----------------------------------------------------------------------------
//
//  channel  signals                                   beat
//  -------  ----------------------------------------  ------------------------
//  in       in_valid_i / in_stall_o                   action, slot, lat, lon
//  out      out_valid_o / out_stall_i                 inside_res
//  cfg      cfg_we_i / cfg_wdata_i                    vertex_count, no wait
//
//  A load beat is written to the store when accepted. A query with n vertices
//  makes n + 1 store reads at one per cycle through the single read port,
//  then passes the edge unit's difference, product and compare stages and the result hand-off.
//  in_stall_o is high from query accept until its result sits in the output
//  register; a waiting result does not block a following load.
//  Reset clears the control state and sets vertex_count to 3; the vertex
//  store is not cleared.
//
module point_in_polygon_test (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [pip_pkg::CntW-1:0]          cfg_wdata_i,
  // input beats
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              action_i,
  input  logic [pip_pkg::IdxW-1:0]          vertex_index_i,
  input  logic signed [pip_pkg::LatW-1:0]   coord_lat_i,
  input  logic signed [pip_pkg::LonW-1:0]   coord_lon_i,
  // result beats
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              inside_res_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state_q, state_d;

  logic [pip_pkg::CntW-1:0] count_q;     // vertex_count register
  logic [pip_pkg::CntW-1:0] count_sat;
  logic [pip_pkg::CntW-1:0] n_q, n_d;    // vertices in this query
  logic [pip_pkg::CntW-1:0] idx_q, idx_d; // read step, 0..n
  logic [pip_pkg::CntW-1:0] last_idx, prev_idx;

  pip_pkg::vertex_t in_vtx, pt_q, prev_q, rd_data;
  logic                     rd_en;
  logic [pip_pkg::IdxW-1:0] rd_addr;
  logic                     rvld_q, first_q;

  logic in_accept, wr_en, q_accept;
  pip_pkg::edge_ctl_t edge_ctl;
  logic edge_busy, edge_inside;

  logic out_valid_q, out_valid_d, out_res_q, out_load;

  assign in_vtx.lat = coord_lat_i;
  assign in_vtx.lon = coord_lon_i;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && (state_q == ST_IDLE);
  assign wr_en      = in_accept && (action_i == pip_pkg::ActLoad);
  assign q_accept   = in_accept && (action_i == pip_pkg::ActQuery);

  // count above the store size saturates
  assign count_sat = (count_q > pip_pkg::CntW'(pip_pkg::MaxVertices)) ?
                     pip_pkg::CntW'(pip_pkg::MaxVertices) : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= pip_pkg::CntW'(3);
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  // Read order: vertex n-1 first (start of the closing edge), then 0..n-1.
  assign last_idx = n_q - pip_pkg::CntW'(1);
  assign prev_idx = idx_q - pip_pkg::CntW'(1);
  assign rd_en    = (state_q == ST_WALK);
  assign rd_addr  = (idx_q == '0) ? last_idx[pip_pkg::IdxW-1:0]
                                  : prev_idx[pip_pkg::IdxW-1:0];

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    idx_d   = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (q_accept) begin
          n_d     = count_sat;
          idx_d   = '0;
          // no vertices: no edges, flag stays clear
          state_d = (count_sat == '0) ? ST_DONE : ST_WALK;
        end
      end
      ST_WALK: begin
        idx_d = idx_q + pip_pkg::CntW'(1);
        if (idx_q == n_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rvld_q && !edge_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      n_q     <= '0;
      idx_q   <= '0;
      rvld_q  <= 1'b0;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      idx_q   <= idx_d;
      rvld_q  <= rd_en;
      first_q <= rd_en && (idx_q == '0);
    end
  end

  // query point and trailing vertex
  always_ff @(posedge clk_i) begin
    if (q_accept) begin
      pt_q <= in_vtx;
    end
    if (rvld_q) begin
      prev_q <= rd_data;
    end
  end

  pip_vertex_store u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (vertex_index_i),
    .wr_data_i (in_vtx),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // edge prev -> current once the first vertex is in hand
  assign edge_ctl.valid = rvld_q && !first_q;
  assign edge_ctl.clear = q_accept;

  pip_edge_unit u_edge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (edge_ctl),
    .a_i      (prev_q),
    .b_i      (rd_data),
    .pt_i     (pt_q),
    .busy_o   (edge_busy),
    .inside_o (edge_inside)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_res_q <= edge_inside;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = out_res_q;

endmodule
